// ===== sv/sle_pkg.sv =====
// Shared types and codes for the sequential list engine.
`timescale 1ns / 1ps
package sle_pkg;

  localparam logic [3:0] REQ_PUSH_BACK  = 4'd0;
  localparam logic [3:0] REQ_PUSH_FRONT = 4'd1;
  localparam logic [3:0] REQ_POP_BACK   = 4'd2;
  localparam logic [3:0] REQ_POP_FRONT  = 4'd3;
  localparam logic [3:0] REQ_FIND       = 4'd4;
  localparam logic [3:0] REQ_DEL_VALUE  = 4'd5;
  localparam logic [3:0] REQ_DEL_POS    = 4'd6;
  localparam logic [3:0] REQ_SORT       = 4'd7;
  localparam logic [3:0] REQ_CLEAR      = 4'd8;
  localparam logic [3:0] REQ_READ       = 4'd9;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_EMPTY    = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_BADPOS   = 3'd4;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_WRITE_TAIL,
    CMD_SHIFT_UP,
    CMD_CLOSE_POS,
    CMD_CLOSE_HIT,
    CMD_SORT_EVEN,
    CMD_SORT_ODD
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] pos;
  } cell_ctrl_t;

endpackage

// ===== sv/sle_cell.sv =====
// One list entry cell with its neighbor moves, key match and sort compare.
`timescale 1ns / 1ps
module sle_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                clk_i,
  input  sle_pkg::cell_ctrl_t ctrl_i,
  input  logic [31:0]         value_i,
  input  logic [CW-1:0]       count_i,
  input  logic [31:0]         left_i,
  input  logic [31:0]         right_i,
  input  logic                hit_i,
  output logic [31:0]         data_o,
  output logic                hit_o
);
  import sle_pkg::*;

  localparam logic [CW+3:0] IdxC  = (CW+4)'(IDX);
  localparam logic [CW+3:0] NextC = (CW+4)'(IDX + 1);
  localparam bit IsEven = (IDX % 2) == 0;

  logic [31:0]   data_q, data_d;
  logic [CW+3:0] cnt_ext, pos_ext;
  logic          in_list, next_in_list, match, lower;

  assign cnt_ext      = (CW+4)'(count_i);
  assign pos_ext      = (CW+4)'(ctrl_i.pos);
  assign in_list      = IdxC < cnt_ext;
  assign next_in_list = NextC < cnt_ext;
  assign match        = in_list && (data_q == value_i);
  assign hit_o        = hit_i | match;

  always_comb begin
    data_d = data_q;
    lower  = 1'b0;
    unique case (ctrl_i.cmd)
      CMD_HOLD: data_d = data_q;
      CMD_WRITE_TAIL: begin
        if (IdxC == cnt_ext) data_d = value_i;
      end
      CMD_SHIFT_UP: data_d = (IDX == 0) ? value_i : left_i;
      CMD_CLOSE_POS: begin
        if (IdxC >= pos_ext) data_d = right_i;
      end
      CMD_CLOSE_HIT: begin
        if (hit_o) data_d = right_i;
      end
      CMD_SORT_EVEN, CMD_SORT_ODD: begin
        lower = (ctrl_i.cmd == CMD_SORT_EVEN) ? IsEven : !IsEven;
        if (lower) begin
          if (next_in_list && ($signed(data_q) > $signed(right_i))) data_d = right_i;
        end else if (IDX >= 1 && in_list) begin
          if ($signed(left_i) > $signed(data_q)) data_d = left_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== sv/sequential_list_engine.sv =====
// Top level of the sequential list engine: request decode, cell chain and result register.
//
//  channel  dir  tdata                              tuser
//  s_axis   in   [31:0] value, [35:32] position    [3:0] req_type
//  m_axis   out  [3:0] found_index, [35:4] read_value, [40:36] length   [2:0] status
//
// Every request except sort completes on its transfer edge: the cells shift, close gaps or compare in
// parallel on the transfer edge and the result is registered behind it.
// Sort runs odd-even transposition passes over the cell chain, one pass a cycle, count
// passes in all, so a sort holds s_axis_tready low from its transfer until the last pass.
// Reset clears the length and the handshake state; entry contents are not cleared.
// A waiting result does not block the next transfer if m_axis_tready is high.
`timescale 1ns / 1ps
module sequential_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[35:32], zero fill
  input  logic [3:0]  s_axis_tuser,   // req_type[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_index[3:0], read_value[35:4], length[40:36]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SORT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q, count_d, round_q;
  logic          phase_q;
  logic          m_valid_q;
  logic [2:0]    status_q, status_d;
  logic [3:0]    found_q, found_d;
  logic [31:0]   read_q, read_d;
  logic [4:0]    length_q;
  logic [CW+4:0] len_ext;

  logic [3:0]    req;
  logic [31:0]   value;
  logic [3:0]    pos;
  logic          accept, load_out;
  cell_ctrl_t    ctrl;
  logic [31:0]   data [DEPTH];
  logic [DEPTH:0] hit;
  logic [3:0]    first_idx;
  logic [31:0]   pos_data;
  logic          pos_ok, full, empty;
  logic [CW+3:0] pos_ext, cnt_ext;

  assign req   = s_axis_tuser;
  assign value = s_axis_tdata[31:0];
  assign pos   = s_axis_tdata[35:32];

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sle_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value),
      .count_i (count_q),
      .left_i  ((g == 0) ? 32'd0 : data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == DEPTH - 1) ? data[g] : data[(g == DEPTH - 1) ? g : g + 1]),
      .hit_i   (hit[g]),
      .data_o  (data[g]),
      .hit_o   (hit[g+1])
    );
  end

  assign pos_ext = (CW+4)'(pos);
  assign cnt_ext = (CW+4)'(count_q);
  assign pos_ok  = pos_ext < cnt_ext;
  assign full    = count_q >= DepthC;
  assign empty   = count_q == '0;

  always_comb begin
    first_idx = '0;
    pos_data  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i+1] && !hit[i]) first_idx = first_idx | 4'(i);
      if ((CW+4)'(i) == pos_ext) pos_data = pos_data | data[i];
    end
  end

  always_comb begin
    ctrl.cmd = CMD_HOLD;
    ctrl.pos = pos;
    count_d  = count_q;
    status_d = STAT_OK;
    found_d  = '0;
    read_d   = '0;
    load_out = 1'b0;
    if (state_q == S_SORT) begin
      ctrl.cmd = phase_q ? CMD_SORT_ODD : CMD_SORT_EVEN;
      load_out = (round_q == CW'(1));
    end else if (accept) begin
      load_out = 1'b1;
      unique case (req)
        REQ_PUSH_BACK: begin
          if (full) status_d = STAT_FULL;
          else begin
            ctrl.cmd = CMD_WRITE_TAIL;
            count_d  = count_q + CW'(1);
          end
        end
        REQ_PUSH_FRONT: begin
          if (full) status_d = STAT_FULL;
          else begin
            ctrl.cmd = CMD_SHIFT_UP;
            count_d  = count_q + CW'(1);
          end
        end
        REQ_POP_BACK: begin
          if (empty) status_d = STAT_EMPTY;
          else count_d = count_q - CW'(1);
        end
        REQ_POP_FRONT: begin
          if (empty) status_d = STAT_EMPTY;
          else begin
            ctrl.cmd = CMD_CLOSE_POS;
            ctrl.pos = 4'd0;
            count_d  = count_q - CW'(1);
          end
        end
        REQ_FIND: begin
          if (hit[DEPTH]) found_d = first_idx;
          else status_d = STAT_NOTFOUND;
        end
        REQ_DEL_VALUE: begin
          if (hit[DEPTH]) begin
            ctrl.cmd = CMD_CLOSE_HIT;
            count_d  = count_q - CW'(1);
          end else status_d = STAT_NOTFOUND;
        end
        REQ_DEL_POS: begin
          if (pos_ok) begin
            ctrl.cmd = CMD_CLOSE_POS;
            count_d  = count_q - CW'(1);
          end else status_d = STAT_BADPOS;
        end
        REQ_SORT: load_out = (count_q <= CW'(1));
        REQ_CLEAR: count_d = '0;
        REQ_READ: begin
          if (pos_ok) read_d = pos_data;
          else status_d = STAT_BADPOS;
        end
        default: status_d = STAT_OK;
      endcase
    end
  end

  assign len_ext = (CW+5)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      round_q   <= '0;
      phase_q   <= 1'b0;
      m_valid_q <= 1'b0;
      status_q  <= STAT_OK;
      found_q   <= '0;
      read_q    <= '0;
      length_q  <= '0;
    end else begin
      count_q <= count_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept && req == REQ_SORT && count_q > CW'(1)) begin
            state_q <= S_SORT;
            round_q <= count_q;
            phase_q <= 1'b0;
          end
        end
        S_SORT: begin
          round_q <= round_q - CW'(1);
          phase_q <= !phase_q;
          if (round_q == CW'(1)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (load_out) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      if (load_out) begin
        status_q <= status_d;
        found_q  <= found_d;
        read_q   <= read_d;
        length_q <= len_ext[4:0];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, length_q, read_q, found_q};

endmodule
